/* hdl/fde_pkg.sv */
package fde_pkg;

  // Filter geometry and sample format.
  localparam int MAX_TAPS     = 64;
  localparam int ADDR_W       = $clog2(MAX_TAPS);
  localparam int SAMPLE_BITS  = 16;
  localparam int COEF_BITS    = 16;

  // Register widths.
  localparam int DEC_W        = 8;
  localparam int TAPS_W       = 7;
  localparam int SELECT_W     = 6;
  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 16;

  // Internal counters. The phase never exceeds the largest decimation plus one,
  // and the sample count only has to reach past the longest window reach.
  localparam int PHASE_W      = 10;
  localparam int COUNT_W      = 11;
  localparam int NRES_W       = 6;
  localparam int RESULT_LIMIT = 34;

  // Arithmetic.
  localparam int PROD_W       = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W        = PROD_W + ADDR_W;
  localparam int SHIFT        = COEF_BITS - 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DECIMATION  = 2'd0,
    CFG_TAP_COUNT   = 2'd1,
    CFG_COEF_SELECT = 2'd2,
    CFG_COEF_VALUE  = 2'd3
  } fde_cfg_index_t;

  typedef struct packed {
    logic                  valid;
    fde_cfg_index_t        index;
    logic [CFG_DATA_W-1:0] data;
  } fde_cfg_t;

  // One input item as classified by the front end.
  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample;
    logic                          final_sample;
    logic                          first;
  } fde_item_t;

  typedef struct packed {
    logic      valid;
    fde_item_t item;
  } fde_push_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] filtered;
    logic                          run_end;
    logic                          signal_end;
  } fde_result_t;

endpackage

/* hdl/fde_front.sv */
module fde_front import fde_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [SAMPLE_BITS-1:0] in_sample,
  input  logic                   in_last,
  input  logic                   queue_full,
  output fde_push_t              push
);

  // Marks the next accepted sample as the start of a new signal.
  logic first_pending;

  assign in_ready = !queue_full;

  always_comb begin
    push.valid             = in_valid && !queue_full;
    push.item.sample       = signed'(in_sample);
    push.item.final_sample = in_last;
    push.item.first        = first_pending;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      first_pending <= 1'b1;
    end else if (push.valid) begin
      first_pending <= in_last;
    end
  end

endmodule

/* hdl/fde_queue.sv */
module fde_queue import fde_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  fde_push_t push,
  output logic      full,
  output fde_push_t head,
  input  logic      pop
);

  fde_item_t  slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign full       = (fill == 2'd2);
  assign head.valid = (fill != 2'd0);
  assign head.item  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      slots[wr_ptr] <= push.item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push.valid) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push.valid, pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* hdl/fde_back.sv */
module fde_back import fde_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  fde_cfg_t    cfg,
  input  fde_push_t   head,
  output logic        pop,
  output fde_result_t res,
  output logic        res_valid,
  input  logic        res_ready
);

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_DECIDE = 7'b0000010,
    ST_MAC    = 7'b0000100,
    ST_DRAIN  = 7'b0001000,
    ST_ROUND  = 7'b0010000,
    ST_EMIT   = 7'b0100000,
    ST_CLOSE  = 7'b1000000
  } fde_state_t;

  localparam int CMP_W      = COUNT_W + 1;
  localparam int RND_W      = ACC_W - SHIFT;
  localparam int ROUND_BIAS = 1 << (SHIFT - 1);
  localparam logic signed [RND_W-1:0] SAT_HI = RND_W'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [RND_W-1:0] SAT_LO = ~SAT_HI;

  // Configuration registers.
  logic [DEC_W-1:0]    decimation;
  logic [TAPS_W-1:0]   tap_count;
  logic [SELECT_W-1:0] coef_select;

  // Memories and their registered read data.
  logic signed [COEF_BITS-1:0]   coef_mem [MAX_TAPS];
  logic signed [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [MAX_TAPS-1:0]           coef_valid;
  logic signed [COEF_BITS-1:0]   coef_rd;
  logic signed [SAMPLE_BITS-1:0] hist_rd;
  logic                          coef_ok;

  // Stream state.
  fde_state_t                    state;
  logic [ADDR_W-1:0]             last_pos;
  logic signed [SAMPLE_BITS-1:0] first_value;
  logic [COUNT_W-1:0]            count;
  logic [PHASE_W-1:0]            phase;
  logic                          pend;
  logic signed [SAMPLE_BITS-1:0] pend_value;
  logic [NRES_W-1:0]             n_res;
  logic                          fin;
  logic                          flush;
  logic                          stage_valid;
  logic signed [SAMPLE_BITS-1:0] stage_value;

  // Multiply-accumulate pipeline.
  logic [ADDR_W-1:0]             tap;
  logic [COUNT_W-1:0]            reach;
  logic [ADDR_W-1:0]             base;
  logic                          va;
  logic                          vb;
  logic                          first_a;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       acc;

  // Derived values.
  logic [DEC_W-1:0]              eff_m;
  logic [TAPS_W-1:0]             eff_t;
  logic [TAPS_W:0]               t_plus;
  logic [TAPS_W-1:0]             half;
  logic [TAPS_W-1:0]             lead;
  logic                          hit_lead;
  logic                          hit_m;
  logic                          at_limit;
  logic                          out_free;
  logic                          sel_first;
  logic                          sel_age0;
  logic [ADDR_W-1:0]             rd_addr;
  logic [ADDR_W-1:0]             wr_addr;
  logic signed [SAMPLE_BITS-1:0] x_b;
  logic signed [COEF_BITS-1:0]   c_b;
  logic signed [ACC_W-1:0]       biased;
  logic signed [RND_W-1:0]       rounded;
  logic signed [SAMPLE_BITS-1:0] sat_value;

  always_comb begin
    eff_m = (decimation == '0) ? DEC_W'(1) : decimation;
    if (tap_count == '0) begin
      eff_t = TAPS_W'(1);
    end else if (tap_count > TAPS_W'(MAX_TAPS)) begin
      eff_t = TAPS_W'(MAX_TAPS);
    end else begin
      eff_t = tap_count;
    end
    t_plus   = {1'b0, eff_t} + (TAPS_W + 1)'(1);
    half     = t_plus[TAPS_W:1];
    lead     = eff_t - half;
    hit_lead = (phase >= PHASE_W'(lead));
    hit_m    = (phase >= PHASE_W'(eff_m));
    at_limit = (n_res == NRES_W'(RESULT_LIMIT));
    out_free = !res_valid || res_ready;
    pop      = (state == ST_IDLE) && head.valid;
    wr_addr  = last_pos + ADDR_W'(1);

    // Window position "tap" lies before the first sample, or past the newest one.
    sel_first = ({1'b0, count} + CMP_W'(tap)) < CMP_W'(reach);
    sel_age0  = CMP_W'(tap) >= CMP_W'(reach);
    rd_addr   = sel_age0 ? last_pos : base + tap;

    x_b = first_a ? first_value : hist_rd;
    c_b = coef_ok ? coef_rd : '0;

    // Round half up, then saturate to the sample width.
    biased  = acc + ACC_W'(ROUND_BIAS);
    rounded = signed'(biased[ACC_W-1:SHIFT]);
    if (rounded > SAT_HI) begin
      sat_value = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
    end else if (rounded < SAT_LO) begin
      sat_value = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};
    end else begin
      sat_value = rounded[SAMPLE_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      decimation  <= DEC_W'(20);
      tap_count   <= TAPS_W'(1);
      coef_select <= '0;
      coef_valid  <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DECIMATION:  decimation  <= cfg.data[DEC_W-1:0];
        CFG_TAP_COUNT:   tap_count   <= cfg.data[TAPS_W-1:0];
        CFG_COEF_SELECT: coef_select <= cfg.data[SELECT_W-1:0];
        CFG_COEF_VALUE:  coef_valid[coef_select] <= 1'b1;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cfg.valid && (cfg.index == CFG_COEF_VALUE)) begin
      coef_mem[coef_select] <= signed'(cfg.data[COEF_BITS-1:0]);
    end
    coef_rd <= coef_mem[tap];
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      hist_mem[wr_addr] <= head.item.sample;
    end
    hist_rd <= hist_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    coef_ok <= coef_valid[tap];
    first_a <= sel_first;
    prod    <= c_b * x_b;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
      vb <= 1'b0;
    end else begin
      va <= (state == ST_MAC);
      vb <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      last_pos    <= '1;
      first_value <= '0;
      count       <= '0;
      phase       <= '0;
      pend        <= 1'b0;
      n_res       <= '0;
      fin         <= 1'b0;
      flush       <= 1'b0;
      stage_valid <= 1'b0;
      res_valid   <= 1'b0;
      tap         <= '0;
      acc         <= '0;
    end else begin
      if (res_ready) begin
        res_valid <= 1'b0;
      end
      if (vb) begin
        acc <= acc + {{(ACC_W - PROD_W){prod[PROD_W-1]}}, prod};
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            last_pos <= wr_addr;
            if (head.item.first) begin
              first_value <= head.item.sample;
            end
            if (count != '1) begin
              count <= count + COUNT_W'(1);
            end
            phase <= phase + PHASE_W'(1);
            n_res <= '0;
            fin   <= head.item.final_sample;
            flush <= 1'b0;
            state <= ST_DECIDE;
          end
        end
        ST_DECIDE: begin
          reach <= COUNT_W'(phase) + COUNT_W'(half);
          base  <= last_pos - ADDR_W'(phase) - ADDR_W'(half) + ADDR_W'(1);
          tap   <= '0;
          if (at_limit) begin
            state <= ST_CLOSE;
          end else if (flush) begin
            if (!hit_m) begin
              state <= ST_CLOSE;
            end else if (pend) begin
              state <= ST_EMIT;
            end else begin
              acc   <= '0;
              state <= ST_MAC;
            end
          end else if (!pend && hit_lead) begin
            acc   <= '0;
            state <= ST_MAC;
          end else if (pend && hit_m) begin
            state <= ST_EMIT;
          end else if (fin) begin
            flush <= 1'b1;
          end else begin
            state <= ST_CLOSE;
          end
        end
        ST_MAC: begin
          if (tap == ADDR_W'(eff_t - TAPS_W'(1))) begin
            state <= ST_DRAIN;
          end else begin
            tap <= tap + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          if (!va && !vb) begin
            state <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          pend_value <= sat_value;
          pend       <= 1'b1;
          state      <= ST_DECIDE;
        end
        ST_EMIT: begin
          // The previous result leaves only once it is known not to be the last.
          if (!stage_valid || out_free) begin
            if (stage_valid) begin
              res.filtered   <= stage_value;
              res.run_end    <= 1'b0;
              res.signal_end <= 1'b0;
              res_valid      <= 1'b1;
            end
            stage_value <= pend_value;
            stage_valid <= 1'b1;
            phase       <= phase - PHASE_W'(eff_m);
            pend        <= 1'b0;
            n_res       <= n_res + NRES_W'(1);
            state       <= ST_DECIDE;
          end
        end
        ST_CLOSE: begin
          if (!stage_valid || out_free) begin
            if (stage_valid) begin
              res.filtered   <= stage_value;
              res.run_end    <= 1'b1;
              res.signal_end <= fin;
              res_valid      <= 1'b1;
              stage_valid    <= 1'b0;
            end
            if (fin) begin
              count <= '0;
              phase <= '0;
              pend  <= 1'b0;
            end
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* hdl/fir_decimator_edge_padded_unit.sv */
// Decimating FIR filter with edge padding for 16-bit signed samples.
// Samples enter on the s_axis stream; s_axis_tlast marks the last sample of a
// signal and flushes the outputs that are still due. Results leave on the
// m_axis stream; m_axis_tlast marks the last result caused by one input
// transfer, m_axis_tuser marks the last result of the whole signal.
// The cfg channel writes registers by index: 0 decimation, 1 tap count,
// 2 coefficient select, 3 coefficient value (stored into the selected tap).
// cfg_ready is always high; registers should change only while the block idles.
// A sample is held in a two-entry queue and taken by the back end one at a time.
// Every result costs one dot product through the single shared multiply-accumulate;
// the back end takes the next sample from the queue only once it has posted the
// results of the current one and returned to idle.
// Synchronous reset clears the stream state, the coefficients (to zero) and the
// registers (decimation 20, one tap). When the receiver stalls, one result waits
// in the output register and one more in the back end; the back end then halts,
// while the queue still takes up to two more samples.
module fir_decimator_edge_padded_unit import fde_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  // Input stream.
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [15:0]           s_axis_tdata,   // [15:0] sample
  input  logic                  s_axis_tlast,   // final_sample
  // Output stream.
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [15:0]           m_axis_tdata,   // [15:0] filtered
  output logic                  m_axis_tlast,   // run_end
  output logic                  m_axis_tuser,   // [0] signal_end
  // Register write channel.
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  fde_push_t   push;
  fde_push_t   head;
  logic        queue_full;
  logic        pop;
  fde_cfg_t    cfg;
  fde_result_t res;

  // Register writes are taken in every cycle.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg.valid = cfg_valid;
    cfg.index = fde_cfg_index_t'(cfg_index);
    cfg.data  = cfg_data;
  end

  // Front end: accepts transfers and marks the first sample of each signal.
  fde_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_sample  (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .queue_full (queue_full),
    .push       (push)
  );

  // Short queue that lets the front end keep accepting while the back end works.
  fde_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (queue_full),
    .head (head),
    .pop  (pop)
  );

  // Back end: history, coefficients, the output schedule and the shared MAC.
  fde_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .pop       (pop),
    .res       (res),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready)
  );

  assign m_axis_tdata = res.filtered;
  assign m_axis_tlast = res.run_end;
  assign m_axis_tuser = res.signal_end;

endmodule
